// File: hw/rtl/ipc_pkg.sv
package ipc_pkg;

    localparam int MAX_N = 1024;
    localparam int MAX_K = 1024;

    localparam int NW    = 11;
    localparam int KW    = 11;
    localparam int CW    = 30;

    localparam int ROW_DEPTH = MAX_K + 1;
    localparam int RW        = $clog2(MAX_K + 1);
    localparam int NRW       = $clog2(MAX_N + 1);
    localparam int DW        = ((RW > NRW) ? RW : NRW) + 1;
    localparam int SW        = CW + 2;

    localparam logic [CW-1:0] PRIME = CW'(1000000007);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_GAP,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

// File: hw/rtl/ipc_ram.sv
module ipc_ram #(
    parameter int DEPTH = 1025,
    parameter int WIDTH = 30
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: hw/rtl/inverse_pair_count_mod_prime.sv
// Counts permutations of n elements with exactly k inversions, modulo 1000000007.
// Input channel: i_valid / o_stall with i_perm_length (n) and i_inversions (k).
// Output channel: o_valid / i_stall with o_count; one result per query.
// A transaction completes at a rising edge with valid high and stall low.
// The block serves one query at a time: o_stall is high from the accepted
// query until its result has been taken.
// Each row passes entry by entry through the prefix-sum unit, with one
// turnaround state between rows so that a row is fully written before the
// next row reads it back.
// Queries with n = 0, or with n or k beyond 1024, skip the row walk.
// The rows live in two ping-pong RAMs with one write and two registered read
// ports each; the read of entry j and entry j-r per cycle sets the rate of
// one entry per clock within a row.
// The result sits in an output register and holds while i_stall is high;
// the next query is taken once it has left.
// Synchronous active-low reset returns the controller to idle and drops any
// pending result; the row stores are not cleared and need not be.
module inverse_pair_count_mod_prime (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [ipc_pkg::NW-1:0] i_perm_length,
    input  logic [ipc_pkg::KW-1:0] i_inversions,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [ipc_pkg::CW-1:0] o_count
);

    import ipc_pkg::*;

    t_state           r_state;
    t_state           n_state;

    logic [NRW-1:0]   r_n;
    logic [RW-1:0]    r_k;
    logic [NRW-1:0]   r_row;
    logic [RW-1:0]    r_j;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_run;

    logic             r_s2_valid;
    logic             r_s2_par;
    logic             r_s2_first;
    logic             r_s2_jz;
    logic             r_s2_eq;
    logic             r_s2_ge;
    logic             r_s2_last;
    logic [RW-1:0]    r_s2_j;

    logic             in_take;
    logic             in_ok;
    logic             issue;
    logic             row_end;
    logic             query_end;
    logic [DW-1:0]    diff;
    logic [RW-1:0]    raddr_b;

    logic [CW-1:0]    rd_a0;
    logic [CW-1:0]    rd_b0;
    logic [CW-1:0]    rd_a1;
    logic [CW-1:0]    rd_b1;
    logic [CW-1:0]    prev_j;
    logic [CW-1:0]    prev_jr;
    logic [CW-1:0]    term_a;
    logic [CW-1:0]    term_b;
    logic [CW-1:0]    term_c;
    logic [SW-1:0]    sum;
    logic [SW-1:0]    sum_red;
    logic [CW-1:0]    new_val;

    assign in_take   = i_valid && !o_stall;
    assign in_ok     = (i_perm_length <= MAX_N) && (i_inversions <= MAX_K);
    assign issue     = (r_state == S_RUN);
    assign row_end   = (r_j == r_k);
    assign query_end = row_end && (r_row == r_n);
    assign diff      = DW'(r_j) - DW'(r_row);
    assign raddr_b   = diff[RW-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (in_ok && (i_perm_length != '0)) begin
                        n_state = S_RUN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RUN: begin
                if (query_end) begin
                    n_state = S_DRAIN;
                end else if (row_end) begin
                    n_state = S_GAP;
                end
            end
            S_GAP:   n_state = S_RUN;
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                o_valid = 1'b0;
            end
            S_DONE: begin
                o_stall = 1'b1;
                o_valid = 1'b1;
            end
            default: begin
                o_stall = 1'b1;
                o_valid = 1'b0;
            end
        endcase
    end

    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_s2_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s2_valid <= issue;
        end
    end

    // Issue stage: walk rows and entries.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_n   <= NRW'(i_perm_length);
            r_k   <= RW'(i_inversions);
            r_row <= NRW'(1);
            r_j   <= '0;
        end else if (issue) begin
            if (row_end) begin
                r_row <= r_row + NRW'(1);
                r_j   <= '0;
            end else begin
                r_j   <= r_j + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_par   <= r_row[0];
        r_s2_first <= (r_row == NRW'(1));
        r_s2_jz    <= (r_j == '0);
        r_s2_eq    <= (diff == '0);
        r_s2_ge    <= !diff[DW-1];
        r_s2_last  <= query_end;
        r_s2_j     <= r_j;
    end

    // Row r writes RAM r[0] and reads the other one; row 0 is implied.
    ipc_ram #(
        .DEPTH (ROW_DEPTH),
        .WIDTH (CW)
    ) u_ram0 (
        .i_clk     (i_clk),
        .i_we      (r_s2_valid && !r_s2_par),
        .i_waddr   (r_s2_j),
        .i_wdata   (new_val),
        .i_raddr_a (r_j),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a0),
        .o_rdata_b (rd_b0)
    );

    ipc_ram #(
        .DEPTH (ROW_DEPTH),
        .WIDTH (CW)
    ) u_ram1 (
        .i_clk     (i_clk),
        .i_we      (r_s2_valid && r_s2_par),
        .i_waddr   (r_s2_j),
        .i_wdata   (new_val),
        .i_raddr_a (r_j),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a1),
        .o_rdata_b (rd_b1)
    );

    assign prev_j  = r_s2_par ? rd_a0 : rd_a1;
    assign prev_jr = r_s2_par ? rd_b0 : rd_b1;

    always_comb begin
        term_a = r_s2_first ? CW'(r_s2_jz) : prev_j;
        term_b = r_s2_jz ? '0 : r_run;
        if (!r_s2_ge) begin
            term_c = '0;
        end else if (r_s2_first) begin
            term_c = CW'(r_s2_eq);
        end else begin
            term_c = prev_jr;
        end
        sum = SW'(term_a) + SW'(term_b) + SW'(PRIME) - SW'(term_c);
        if (sum >= (SW'(PRIME) << 1)) begin
            sum_red = sum - (SW'(PRIME) << 1);
        end else if (sum >= SW'(PRIME)) begin
            sum_red = sum - SW'(PRIME);
        end else begin
            sum_red = sum;
        end
        new_val = sum_red[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_run <= new_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            if (!in_ok) begin
                r_count <= '0;
            end else begin
                r_count <= CW'(i_inversions == '0);
            end
        end else if (r_s2_valid && r_s2_last) begin
            r_count <= new_val;
        end
    end

`ifndef SYNTH
    a_s2_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> $past(r_state) == S_RUN)
        else $error("compute stage active without an issue");

    a_s2_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> r_s2_j <= r_k)
        else $error("row write beyond inversion count");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_row != '0) && (r_row <= r_n))
        else $error("row counter out of range");

    a_count_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_count < PRIME)
        else $error("result not reduced modulo prime");

    a_drain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> r_s2_valid && r_s2_last)
        else $error("drain without final entry");
`endif

endmodule
